### src/hsmm_pkg.sv
// ----------------------------------------------------------------------------
// hsmm_pkg
// Shared types and constants of the semi-Markov Viterbi decoder.
// ----------------------------------------------------------------------------
package hsmm_pkg;

	localparam int DEF_MAX_STATES    = 8;
	localparam int DEF_MAX_DURATIONS = 16;
	localparam int DEF_MAX_OBS       = 64;
	localparam int DEF_SCORE_WIDTH   = 40;

	typedef enum logic [2:0] {
		OP_TRANS = 3'd0,
		OP_INIT  = 3'd1,
		OP_DUR   = 3'd2,
		OP_EMIS  = 3'd3,
		OP_START = 3'd4
	} op_t;

	localparam logic [1:0] REG_MIN_LEN   = 2'd0;
	localparam logic [1:0] REG_STATES    = 2'd1;
	localparam logic [1:0] REG_DURATIONS = 2'd2;

	typedef enum logic [17:0] {
		S_IDLE    = 18'h00001,
		S_T_INIT  = 18'h00002,
		S_D_CHK   = 18'h00004,
		S_RD_E    = 18'h00008,
		S_ADD_E   = 18'h00010,
		S_INIT_C  = 18'h00020,
		S_RD_T    = 18'h00040,
		S_ADD_T   = 18'h00080,
		S_ACS     = 18'h00100,
		S_WR_B    = 18'h00200,
		S_FIN_RD  = 18'h00400,
		S_FIN_CMP = 18'h00800,
		S_TB_CHK  = 18'h01000,
		S_TB_RD   = 18'h02000,
		S_TB_USE  = 18'h04000,
		S_EM_RD   = 18'h08000,
		S_EM_LOAD = 18'h10000,
		S_EM_WAIT = 18'h20000
	} fsm_t;

endpackage

### src/hsmm_viterbi_decoder_core.sv
// ----------------------------------------------------------------------------
// hsmm_viterbi_decoder_core
// Semi-Markov Viterbi decoder with stored model scores and traceback.
// ----------------------------------------------------------------------------
// Load requests (transition, initial, duration and emission scores) are taken
// one per cycle. A start request holds intake while the decode runs through a
// single saturating adder and comparator, one addition per cycle. Per end time
// and state it tries each fitting duration and keeps the best: one starting at
// time zero adds the initial score, any other is tried against each active
// predecessor. Then come the final state scan, traceback by segment and each
// result, held during any output stall. Results leave in path order with last
// set on the final segment; an unreachable end gives one result with no_path.
// ----------------------------------------------------------------------------
module hsmm_viterbi_decoder_core
	import hsmm_pkg::*;
#(
	parameter int MAX_STATES    = DEF_MAX_STATES,
	parameter int MAX_DURATIONS = DEF_MAX_DURATIONS,
	parameter int MAX_OBS       = DEF_MAX_OBS,
	parameter int SCORE_WIDTH   = DEF_SCORE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [6:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    operation,
	input  logic [2:0]                    state_a,
	input  logic [2:0]                    state_b,
	input  logic [5:0]                    start_time,
	input  logic [3:0]                    duration_step,
	input  logic signed [31:0]            log_value,
	input  logic [6:0]                    obs_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    seg_state,
	output logic [6:0]                    seg_length,
	output logic                          last,
	output logic                          no_path,
	output logic signed [SCORE_WIDTH-1:0] path_score
);

	localparam int SW   = SCORE_WIDTH;
	localparam int SIW  = $clog2(MAX_STATES);
	localparam int CW   = $clog2(MAX_STATES + 1);
	localparam int DIW  = (MAX_DURATIONS > 1) ? $clog2(MAX_DURATIONS) : 1;
	localparam int DCW  = $clog2(MAX_DURATIONS + 1);
	localparam int TW   = $clog2(MAX_OBS);
	localparam int NW   = $clog2(MAX_OBS + 1);
	localparam int TRW  = $clog2(MAX_STATES * MAX_STATES);
	localparam int LAW  = $clog2(MAX_STATES * MAX_DURATIONS);
	localparam int EAW  = $clog2(MAX_STATES * MAX_OBS * MAX_DURATIONS);
	localparam int BAW  = $clog2(MAX_STATES * MAX_OBS);
	localparam int STKW = SIW + 7;

	localparam logic signed [SW-1:0] SC_NEG  = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] SC_MAX  = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SC_LOWF = {1'b1, {(SW-2){1'b0}}, 1'b1};
	localparam logic [CW-1:0]        NO_PREV = CW'(MAX_STATES);

	function automatic logic signed [SW-1:0] to_score(input logic [31:0] raw);
		logic signed [31:0] v;
		v = signed'(raw);
		if (raw == 32'h8000_0000)
			return SC_NEG;
		return SW'(v);
	endfunction

	function automatic logic signed [SW-1:0] sadd(input logic signed [SW-1:0] a,
			input logic signed [SW-1:0] b);
		logic signed [SW:0] s;
		s = (SW+1)'(a) + (SW+1)'(b);
		if (a == SC_NEG || b == SC_NEG)
			return SC_NEG;
		if (s > (SW+1)'(SC_MAX))
			return SC_MAX;
		if (s < (SW+1)'(SC_LOWF))
			return SC_LOWF;
		return s[SW-1:0];
	endfunction

	// stores
	logic [31:0]          trans_mem [MAX_STATES*MAX_STATES];
	logic [31:0]          init_mem  [MAX_STATES];
	logic [31:0]          lenp_mem  [MAX_STATES*MAX_DURATIONS];
	logic [31:0]          emis_mem  [MAX_STATES*MAX_OBS*MAX_DURATIONS];
	logic signed [SW-1:0] bsc_mem   [MAX_STATES*MAX_OBS];
	logic [6:0]           blen_mem  [MAX_STATES*MAX_OBS];
	logic [CW-1:0]        bprv_mem  [MAX_STATES*MAX_OBS];
	logic [STKW-1:0]      stk_mem   [MAX_OBS];

	logic [31:0]          tr_rd_q, in_rd_q, lp_rd_q, em_rd_q;
	logic signed [SW-1:0] bs_rd_q;
	logic [6:0]           bl_rd_q;
	logic [CW-1:0]        bp_rd_q;
	logic [STKW-1:0]      stk_rd_q;

	fsm_t                 state_q;
	logic [6:0]           mn_q, mnc_q;
	logic [3:0]           ns_q;
	logic [4:0]           nd_q;
	logic [CW-1:0]        nsc_q;
	logic [DCW-1:0]       ndc_q;
	logic [NW-1:0]        n_q;
	logic [TW-1:0]        t_q;
	logic [SIW-1:0]       j_q, i_q;
	logic [DCW-1:0]       d_q;
	logic signed [8:0]    f_q, tt_q;
	logic signed [SW-1:0] sc_q, e_q, c1_q, fin_q;
	logic [6:0]           len_q;
	logic [CW-1:0]        pv_q, cur_q;
	logic [NW-1:0]        cnt_q, k_q;
	logic                 out_valid_q, last_q, no_path_q;
	logic [2:0]           seg_state_q;
	logic [6:0]           seg_length_q;
	logic signed [SW-1:0] path_score_q;

	logic                 in_acc;
	logic signed [8:0]    f_c;
	logic signed [SW-1:0] add_a, add_b, cand;
	logic signed [SW-1:0] cmp_a, cmp_b;
	logic                 cmp_gt;
	logic [6:0]           len_c;
	logic signed [9:0]    tt_next;
	logic                 trans_we, init_we, lenp_we, emis_we, best_we, stk_we;
	logic [TRW-1:0]       tr_wa, tr_ra;
	logic [LAW-1:0]       lp_wa, lp_ra;
	logic [EAW-1:0]       em_wa, em_ra;
	logic [BAW-1:0]       b_wa, b_ra;
	logic [TW-1:0]        stk_ra;
	logic [SIW-1:0]       init_wa;
	logic                 tb_bad;

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign seg_state  = seg_state_q;
	assign seg_length = seg_length_q;
	assign last       = last_q;
	assign no_path    = no_path_q;
	assign path_score = path_score_q;

	always_comb begin
		f_c     = 9'(int'(t_q) + 1 - int'(mnc_q) - int'(d_q));
		len_c   = 7'(int'(mnc_q) + int'(d_q));
		tt_next = 10'(int'(tt_q) - int'(bl_rd_q));
		tb_bad  = (bl_rd_q == 7'd0) || (int'(bl_rd_q) > int'(tt_q) + 1);

		// steer the shared adder by sequencer step
		case (state_q)
			S_ADD_E: begin
				add_a = to_score(em_rd_q);
				add_b = to_score(lp_rd_q);
			end
			S_INIT_C: begin
				add_a = e_q;
				add_b = to_score(in_rd_q);
			end
			S_ADD_T: begin
				add_a = e_q;
				add_b = to_score(tr_rd_q);
			end
			default: begin
				add_a = c1_q;
				add_b = bs_rd_q;
			end
		endcase
		cand   = sadd(add_a, add_b);
		cmp_a  = (state_q == S_FIN_CMP) ? bs_rd_q : cand;
		cmp_b  = (state_q == S_FIN_CMP) ? fin_q : sc_q;
		cmp_gt = (cmp_a > cmp_b);

		trans_we = in_acc && operation == OP_TRANS && int'(state_a) < MAX_STATES
			&& int'(state_b) < MAX_STATES;
		init_we  = in_acc && operation == OP_INIT && int'(state_a) < MAX_STATES;
		lenp_we  = in_acc && operation == OP_DUR && int'(state_a) < MAX_STATES
			&& int'(duration_step) < MAX_DURATIONS;
		emis_we  = in_acc && operation == OP_EMIS && int'(state_a) < MAX_STATES
			&& int'(start_time) < MAX_OBS && int'(duration_step) < MAX_DURATIONS;
		best_we  = (state_q == S_WR_B);
		stk_we   = (state_q == S_TB_USE) && !tb_bad;

		tr_wa   = TRW'(int'(state_a) * MAX_STATES + int'(state_b));
		init_wa = SIW'(state_a);
		lp_wa   = LAW'(int'(state_a) * MAX_DURATIONS + int'(duration_step));
		em_wa   = EAW'((int'(state_a) * MAX_OBS + int'(start_time)) * MAX_DURATIONS
			+ int'(duration_step));
		tr_ra   = TRW'(int'(i_q) * MAX_STATES + int'(j_q));
		lp_ra   = LAW'(int'(j_q) * MAX_DURATIONS + int'(d_q[DIW-1:0]));
		em_ra   = EAW'((int'(j_q) * MAX_OBS + int'(f_q)) * MAX_DURATIONS
			+ int'(d_q[DIW-1:0]));
		b_wa    = BAW'(int'(j_q) * MAX_OBS + int'(t_q));
		case (state_q)
			S_FIN_RD: b_ra = BAW'(int'(i_q) * MAX_OBS + int'(n_q) - 1);
			S_TB_RD:  b_ra = BAW'(int'(cur_q) * MAX_OBS + int'(tt_q));
			default:  b_ra = BAW'(int'(i_q) * MAX_OBS + int'(f_q) - 1);
		endcase
		stk_ra  = TW'(int'(cnt_q) - 1 - int'(k_q));
	end

	// model stores: written by load requests
	always_ff @(posedge clk) begin
		if (trans_we)
			trans_mem[tr_wa] <= log_value;
		if (state_q == S_RD_T)
			tr_rd_q <= trans_mem[tr_ra];
	end

	always_ff @(posedge clk) begin
		if (init_we)
			init_mem[init_wa] <= log_value;
		if (state_q == S_RD_E)
			in_rd_q <= init_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (lenp_we)
			lenp_mem[lp_wa] <= log_value;
		if (state_q == S_RD_E)
			lp_rd_q <= lenp_mem[lp_ra];
	end

	always_ff @(posedge clk) begin
		if (emis_we)
			emis_mem[em_wa] <= log_value;
		if (state_q == S_RD_E)
			em_rd_q <= emis_mem[em_ra];
	end

	// decode tables
	always_ff @(posedge clk) begin
		if (best_we) begin
			bsc_mem[b_wa]  <= sc_q;
			blen_mem[b_wa] <= len_q;
			bprv_mem[b_wa] <= pv_q;
		end
		if (state_q == S_RD_T || state_q == S_FIN_RD || state_q == S_TB_RD) begin
			bs_rd_q <= bsc_mem[b_ra];
			bl_rd_q <= blen_mem[b_ra];
			bp_rd_q <= bprv_mem[b_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stk_mem[cnt_q[TW-1:0]] <= {cur_q[SIW-1:0], bl_rd_q};
		if (state_q == S_EM_RD)
			stk_rd_q <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mn_q         <= 7'd1;
			ns_q         <= 4'd8;
			nd_q         <= 5'd16;
			mnc_q        <= 7'd1;
			nsc_q        <= '0;
			ndc_q        <= '0;
			n_q          <= '0;
			t_q          <= '0;
			j_q          <= '0;
			i_q          <= '0;
			d_q          <= '0;
			f_q          <= '0;
			tt_q         <= '0;
			sc_q         <= SC_NEG;
			e_q          <= SC_NEG;
			c1_q         <= SC_NEG;
			fin_q        <= SC_NEG;
			len_q        <= '0;
			pv_q         <= NO_PREV;
			cur_q        <= '0;
			cnt_q        <= '0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
			last_q       <= 1'b0;
			no_path_q    <= 1'b0;
			seg_state_q  <= '0;
			seg_length_q <= '0;
			path_score_q <= SC_NEG;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_LEN:   mn_q <= cfg_data;
					REG_STATES:    ns_q <= cfg_data[3:0];
					REG_DURATIONS: nd_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && operation == OP_START) begin
						mnc_q <= (mn_q == 7'd0) ? 7'd1 : ((mn_q > 7'd64) ? 7'd64 : mn_q);
						nsc_q <= (ns_q == 4'd0) ? CW'(1)
							: ((int'(ns_q) > MAX_STATES) ? CW'(MAX_STATES) : CW'(ns_q));
						ndc_q <= (nd_q == 5'd0) ? DCW'(1)
							: ((int'(nd_q) > MAX_DURATIONS) ? DCW'(MAX_DURATIONS)
							: DCW'(nd_q));
						n_q   <= (obs_count == 7'd0) ? NW'(1)
							: ((int'(obs_count) > MAX_OBS) ? NW'(MAX_OBS) : NW'(obs_count));
						t_q     <= '0;
						j_q     <= '0;
						state_q <= S_T_INIT;
					end
				end
				S_T_INIT: begin
					sc_q    <= SC_NEG;
					len_q   <= '0;
					pv_q    <= NO_PREV;
					d_q     <= '0;
					state_q <= S_D_CHK;
				end
				S_D_CHK: begin
					// later durations start even earlier, so stop at the first misfit
					if (d_q == ndc_q || f_c < 0) begin
						state_q <= S_WR_B;
					end else begin
						f_q     <= f_c;
						state_q <= S_RD_E;
					end
				end
				S_RD_E: state_q <= S_ADD_E;
				S_ADD_E: begin
					e_q <= cand;
					i_q <= '0;
					state_q <= (f_q == 0) ? S_INIT_C : S_RD_T;
				end
				S_INIT_C: begin
					if (cmp_gt) begin
						sc_q  <= cand;
						len_q <= len_c;
						pv_q  <= NO_PREV;
					end
					d_q     <= d_q + 1'b1;
					state_q <= S_D_CHK;
				end
				S_RD_T: state_q <= S_ADD_T;
				S_ADD_T: begin
					c1_q    <= cand;
					state_q <= S_ACS;
				end
				S_ACS: begin
					// strict compare: first best holds
					if (cmp_gt) begin
						sc_q  <= cand;
						len_q <= len_c;
						pv_q  <= CW'(i_q);
					end
					if (int'(i_q) == int'(nsc_q) - 1) begin
						d_q     <= d_q + 1'b1;
						state_q <= S_D_CHK;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RD_T;
					end
				end
				S_WR_B: begin
					if (int'(j_q) == int'(nsc_q) - 1) begin
						j_q <= '0;
						if (int'(t_q) == int'(n_q) - 1) begin
							i_q     <= '0;
							state_q <= S_FIN_RD;
						end else begin
							t_q     <= t_q + 1'b1;
							state_q <= S_T_INIT;
						end
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_T_INIT;
					end
				end
				S_FIN_RD: state_q <= S_FIN_CMP;
				S_FIN_CMP: begin
					if (i_q == '0 || cmp_gt) begin
						fin_q <= bs_rd_q;
						cur_q <= CW'(i_q);
					end
					if (int'(i_q) == int'(nsc_q) - 1) begin
						tt_q    <= 9'(int'(n_q) - 1);
						cnt_q   <= '0;
						state_q <= S_TB_CHK;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_FIN_RD;
					end
				end
				S_TB_CHK: begin
					if (fin_q == SC_NEG) begin
						cnt_q <= '0;
						state_q <= S_EM_LOAD;
					end else if (tt_q < 0) begin
						k_q     <= '0;
						state_q <= (cnt_q == '0) ? S_EM_LOAD : S_EM_RD;
					end else if (int'(cur_q) >= int'(nsc_q) || int'(cnt_q) >= MAX_OBS) begin
						cnt_q   <= '0;
						state_q <= S_EM_LOAD;
					end else begin
						state_q <= S_TB_RD;
					end
				end
				S_TB_RD: state_q <= S_TB_USE;
				S_TB_USE: begin
					if (tb_bad || (tt_next >= 0 && bp_rd_q == NO_PREV)) begin
						cnt_q   <= '0;
						state_q <= S_EM_LOAD;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						tt_q    <= tt_next[8:0];
						cur_q   <= bp_rd_q;
						state_q <= S_TB_CHK;
					end
				end
				S_EM_RD: state_q <= S_EM_LOAD;
				S_EM_LOAD: begin
					// an empty path here means no segmentation reaches the end
					if (cnt_q == '0) begin
						seg_state_q  <= '0;
						seg_length_q <= '0;
						last_q       <= 1'b1;
						no_path_q    <= 1'b1;
						path_score_q <= SC_NEG;
					end else begin
						seg_state_q  <= 3'(stk_rd_q[STKW-1:7]);
						seg_length_q <= stk_rd_q[6:0];
						last_q       <= (int'(k_q) == int'(cnt_q) - 1);
						no_path_q    <= 1'b0;
						path_score_q <= fin_q;
					end
					out_valid_q <= 1'b1;
					state_q     <= S_EM_WAIT;
				end
				S_EM_WAIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_only_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_EM_WAIT)
		else $error("result shown outside the output wait state");

	a_no_path_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_path |-> last && seg_length == 7'd0)
		else $error("no-path result not marked last");

	a_intake_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("intake open while a result is pending");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= MAX_OBS)
		else $error("traceback stack overrun");

endmodule
